[rtl/spcr_pkg.sv]
package spcr_pkg;

   // Frame geometry.
   localparam int FRAME_NIBBLES = 13;
   localparam int FRAME_BITS    = 52;
   localparam int BIT_COUNT_W   = 6;
   localparam int NIBBLE_IDX_W  = 4;
   localparam int DIGIT_COUNT   = 6;

   // Nibble positions inside the frame.
   localparam int SIGN_NIBBLE       = 4;
   localparam int FIRST_DIGIT       = 5;
   localparam int POINT_NIBBLE      = 11;
   localparam int UNIT_NIBBLE       = 12;
   localparam logic [3:0] SIGN_NEG  = 4'h8;

   // Register widths and reset values.
   localparam int MS_W   = 16;
   localparam int OVR_W  = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [MS_W-1:0] IDLE_WAIT_RESET    = 16'd10;
   localparam logic [MS_W-1:0] TIMEOUT_RESET      = 16'd250;
   localparam logic [3:0]      POINT_EXPECT_RESET = 4'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_WAIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_EXPECT = 2'd2;

   // Input item kinds.
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_EDGE = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SEND = 2'd1,
      PH_WAIT = 2'd2
   } phase_type;

   typedef logic [FRAME_NIBBLES-1:0][3:0] frame_type;

   typedef struct packed {
      logic mode;
      logic data_bit;
   } req_payload_type;

   typedef struct packed {
      logic        request_active;
      logic        frame_done;
      logic        frame_error;
      logic        timed_out;
      logic        negative;
      logic [23:0] digit_nibbles;
      logic [3:0]  point_position;
      logic        unit_inch;
      logic [7:0]  overrun_count;
   } rsp_payload_type;

   // Control from the top level into the bit capture.
   typedef struct packed {
      logic bit_strobe;
      logic data_bit;
      logic clear;
   } capture_ctl_type;

   // Next-state view of the request sequencer for the current item.
   typedef struct packed {
      logic request_active;
      logic frame_done;
      logic timed_out;
      logic clear;
   } seq_status_type;

   // Fields decoded from a completed frame.
   typedef struct packed {
      logic        frame_error;
      logic        negative;
      logic [23:0] digit_nibbles;
      logic [3:0]  point_position;
      logic        unit_inch;
   } decode_type;

endpackage

[rtl/spcr_capture.sv]
module spcr_capture
   import spcr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  capture_ctl_type ctl,
   output frame_type       frame,
   output logic            frame_full,
   output logic [OVR_W-1:0] overrun_next
);

   frame_type              nibble_ff, nibble_in;
   logic [BIT_COUNT_W-1:0] bit_count_ff, bit_count_in;
   logic [OVR_W-1:0]       overrun_ff, overrun_in;

   assign frame_full = (bit_count_ff >= BIT_COUNT_W'(FRAME_BITS));

   // Pack caliper bits LSB first; once the frame is full, count the extra beats.
   always_comb begin
      nibble_in    = nibble_ff;
      bit_count_in = bit_count_ff;
      overrun_in   = overrun_ff;
      if (ctl.clear) begin
         nibble_in    = '0;
         bit_count_in = '0;
      end else if (ctl.bit_strobe) begin
         if (frame_full) begin
            overrun_in = overrun_ff + OVR_W'(1);
         end else begin
            if (ctl.data_bit) begin
               nibble_in[bit_count_ff[BIT_COUNT_W-1:2]][bit_count_ff[1:0]] = 1'b1;
            end
            bit_count_in = bit_count_ff + BIT_COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nibble_ff    <= '0;
         bit_count_ff <= '0;
         overrun_ff   <= '0;
      end else begin
         nibble_ff    <= nibble_in;
         bit_count_ff <= bit_count_in;
         overrun_ff   <= overrun_in;
      end
   end

   assign frame        = nibble_ff;
   assign overrun_next = overrun_in;

endmodule

[rtl/spcr_seq.sv]
module spcr_seq
   import spcr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            tick,
   input  logic            frame_full,
   input  logic [MS_W-1:0] idle_wait_ms,
   input  logic [MS_W-1:0] timeout_ms,
   output seq_status_type  status
);

   phase_type       phase_ff, phase_in;
   logic [MS_W-1:0] ms_count_ff, ms_count_in;
   logic            req_line_ff, req_line_in;
   logic [MS_W-1:0] ms_next;

   assign ms_next = ms_count_ff + MS_W'(1);

   // Millisecond loop: idle wait, request and clear, then wait for a frame or the timeout.
   always_comb begin
      phase_in       = phase_ff;
      ms_count_in    = ms_count_ff;
      req_line_in    = req_line_ff;
      status.frame_done = 1'b0;
      status.timed_out  = 1'b0;
      status.clear      = 1'b0;
      if (tick) begin
         ms_count_in = ms_next;
         unique case (phase_ff)
            PH_SEND: begin
               status.clear = 1'b1;
               req_line_in  = 1'b1;
               phase_in     = PH_WAIT;
            end
            PH_WAIT: begin
               // A complete frame takes precedence over the timeout.
               if (frame_full) begin
                  req_line_in       = 1'b0;
                  status.frame_done = 1'b1;
                  phase_in          = PH_IDLE;
                  ms_count_in       = '0;
               end else if (ms_next > timeout_ms) begin
                  status.timed_out = 1'b1;
                  phase_in         = PH_IDLE;
                  ms_count_in      = '0;
               end
            end
            default: begin
               req_line_in = 1'b0;
               phase_in    = PH_IDLE;
               if (ms_next == idle_wait_ms) begin
                  phase_in    = PH_SEND;
                  ms_count_in = '0;
               end
            end
         endcase
      end
      status.request_active = req_line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         ms_count_ff <= '0;
         req_line_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         ms_count_ff <= ms_count_in;
         req_line_ff <= req_line_in;
      end
   end

endmodule

[rtl/spcr_decode.sv]
module spcr_decode
   import spcr_pkg::*;
(
   input  frame_type  frame,
   input  logic       frame_done,
   input  logic [3:0] expected_point,
   output decode_type fields
);

   logic [23:0] digits;

   // Six reading digits, the first one in the top nibble.
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         digits[4*(DIGIT_COUNT-1-i) +: 4] = frame[FIRST_DIGIT + i];
      end
   end

   // Decoded fields show only with a completed frame.
   always_comb begin
      fields = '0;
      if (frame_done) begin
         fields.frame_error    = (frame[POINT_NIBBLE] != expected_point);
         fields.negative       = (frame[SIGN_NIBBLE] == SIGN_NEG);
         fields.digit_nibbles  = digits;
         fields.point_position = frame[POINT_NIBBLE];
         fields.unit_inch      = (frame[UNIT_NIBBLE] != 4'd0);
      end
   end

endmodule

[rtl/caliper_spc_frame_reader.sv]
// Reader for the 52-bit serial frame of a digital caliper. Each input beat is
// either a one-millisecond tick or a falling caliper clock edge with its data
// bit; every accepted beat yields exactly one result beat. A beat can be
// accepted in every cycle and its result is offered in the next cycle: the state
// update is a single pass of logic into the result register. A new beat enters
// in the same cycle that the previous result is taken; while a result is
// stalled, the input is stalled too.
// Configuration writes are accepted at any time but are meant for idle
// periods; indexes beyond the register list are ignored.
module caliper_spc_frame_reader
   import spcr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [MS_W-1:0]  idle_wait_ff, idle_wait_in;
   logic [MS_W-1:0]  timeout_ff, timeout_in;
   logic [3:0]       point_expect_ff, point_expect_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic             accept;
   capture_ctl_type  cap_ctl;
   seq_status_type   seq_status;
   frame_type        frame;
   logic             frame_full;
   logic [OVR_W-1:0] overrun_next;
   decode_type       decoded;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      idle_wait_in    = idle_wait_ff;
      timeout_in      = timeout_ff;
      point_expect_in = point_expect_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IDLE_WAIT:    idle_wait_in    = csr_data;
            CSR_TIMEOUT:      timeout_in      = csr_data;
            CSR_POINT_EXPECT: point_expect_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_wait_ff    <= IDLE_WAIT_RESET;
         timeout_ff      <= TIMEOUT_RESET;
         point_expect_ff <= POINT_EXPECT_RESET;
      end else begin
         idle_wait_ff    <= idle_wait_in;
         timeout_ff      <= timeout_in;
         point_expect_ff <= point_expect_in;
      end
   end

   // Input handshake: room in the result register or it empties this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   spcr_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .tick         (accept && (req_payload.mode == MODE_TICK)),
      .frame_full   (frame_full),
      .idle_wait_ms (idle_wait_ff),
      .timeout_ms   (timeout_ff),
      .status       (seq_status)
   );

   assign cap_ctl.bit_strobe = accept && (req_payload.mode == MODE_EDGE);
   assign cap_ctl.data_bit   = req_payload.data_bit;
   assign cap_ctl.clear      = seq_status.clear;

   spcr_capture u_capture (
      .clock        (clock),
      .reset        (reset),
      .ctl          (cap_ctl),
      .frame        (frame),
      .frame_full   (frame_full),
      .overrun_next (overrun_next)
   );

   spcr_decode u_decode (
      .frame          (frame),
      .frame_done     (seq_status.frame_done),
      .expected_point (point_expect_ff),
      .fields         (decoded)
   );

   // Result register.
   always_comb begin
      rsp_payload_in.request_active = seq_status.request_active;
      rsp_payload_in.frame_done     = seq_status.frame_done;
      rsp_payload_in.frame_error    = decoded.frame_error;
      rsp_payload_in.timed_out      = seq_status.timed_out;
      rsp_payload_in.negative       = decoded.negative;
      rsp_payload_in.digit_nibbles  = decoded.digit_nibbles;
      rsp_payload_in.point_position = decoded.point_position;
      rsp_payload_in.unit_inch      = decoded.unit_inch;
      rsp_payload_in.overrun_count  = overrun_next;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[rtl/spcr_checker.sv]
module spcr_checker
   import spcr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_payload_type        rsp_payload
);

   // A stalled result beat holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // Every accepted input beat shows a result beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted beat produced no result");

   // A frame and a timeout are never reported together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.frame_done && rsp_payload.timed_out))
      else $error("frame done and timeout in one beat");

   // Decoded fields stay clear outside a completed frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.frame_done |->
         !rsp_payload.frame_error && !rsp_payload.negative &&
         rsp_payload.digit_nibbles == 24'd0 && rsp_payload.point_position == 4'd0 &&
         !rsp_payload.unit_inch)
      else $error("decoded fields set without a frame");

   // The request line is released on the tick that takes a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_done |-> !rsp_payload.request_active)
      else $error("request still active on a completed frame");

endmodule

bind caliper_spc_frame_reader spcr_checker u_spcr_checker (.*);

[sim/caliper_spc_frame_checker.sv]
module caliper_spc_frame_checker
   import spcr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_payload_type        req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the configuration registers.
   logic [MS_W-1:0]        idle_wait;
   logic [MS_W-1:0]        timeout_limit;
   logic [3:0]             point_expect;

   // Shadow copy of the reader state.
   phase_type              phase;
   logic [MS_W-1:0]        ms_count;
   logic [BIT_COUNT_W-1:0] bits_held;
   logic [3:0]             nibbles [FRAME_NIBBLES];
   logic [OVR_W-1:0]       overruns;
   logic                   line_asserted;

   // Readings computed from accepted beats, oldest first.
   rsp_payload_type        pending_readings [$];

   // Applies one input beat to the shadow state and returns the reading it yields.
   function automatic rsp_payload_type next_reading(req_payload_type beat);
      rsp_payload_type r;
      r = '0;
      if (beat.mode == MODE_EDGE) begin
         // Bits fill nibbles LSB first; a full frame only counts overruns.
         if (bits_held >= FRAME_BITS) begin
            overruns = overruns + 1'b1;
         end else begin
            if (beat.data_bit)
               nibbles[bits_held[5:2]][bits_held[1:0]] = 1'b1;
            bits_held = bits_held + 1'b1;
         end
      end else begin
         ms_count = ms_count + 1'b1;
         case (phase)
            PH_SEND: begin
               bits_held = '0;
               foreach (nibbles[n]) nibbles[n] = '0;
               line_asserted = 1'b1;
               phase = PH_WAIT;
            end
            PH_WAIT: begin
               // A complete frame takes priority over the timeout.
               if (bits_held == FRAME_BITS) begin
                  line_asserted = 1'b0;
                  r.frame_done = 1'b1;
                  r.frame_error = nibbles[POINT_NIBBLE] != point_expect;
                  r.negative = nibbles[SIGN_NIBBLE] == SIGN_NEG;
                  for (int i = FIRST_DIGIT; i < FIRST_DIGIT + DIGIT_COUNT; i++)
                     r.digit_nibbles = {r.digit_nibbles[19:0], nibbles[i]};
                  r.point_position = nibbles[POINT_NIBBLE];
                  r.unit_inch = nibbles[UNIT_NIBBLE] != 4'd0;
                  phase = PH_IDLE;
                  ms_count = '0;
               end
               if (ms_count > timeout_limit) begin
                  r.timed_out = 1'b1;
                  phase = PH_IDLE;
                  ms_count = '0;
               end
            end
            default: begin
               line_asserted = 1'b0;
               phase = PH_IDLE;
               if (ms_count == idle_wait) begin
                  phase = PH_SEND;
                  ms_count = '0;
               end
            end
         endcase
      end
      r.request_active = line_asserted;
      r.overrun_count = overruns;
      return r;
   endfunction

   function automatic string reading_text(rsp_payload_type r);
      return $sformatf("req=%0b done=%0b err=%0b tmo=%0b neg=%0b digits=%06h point=%0h inch=%0b ovr=%0d",
                       r.request_active, r.frame_done, r.frame_error, r.timed_out,
                       r.negative, r.digit_nibbles, r.point_position, r.unit_inch,
                       r.overrun_count);
   endfunction

   // Result beats are checked before the same edge's input beat is queued.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         idle_wait = IDLE_WAIT_RESET;
         timeout_limit = TIMEOUT_RESET;
         point_expect = POINT_EXPECT_RESET;
         phase = PH_IDLE;
         ms_count = '0;
         bits_held = '0;
         foreach (nibbles[n]) nibbles[n] = '0;
         overruns = '0;
         line_asserted = 1'b0;
         pending_readings.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result beat with nothing expected: %s", $realtime,
                           reading_text(rsp_payload));
            end else begin
               want = pending_readings.pop_front();
               if (rsp_payload.request_active !== want.request_active ||
                   rsp_payload.frame_done     !== want.frame_done     ||
                   rsp_payload.frame_error    !== want.frame_error    ||
                   rsp_payload.timed_out      !== want.timed_out      ||
                   rsp_payload.negative       !== want.negative       ||
                   rsp_payload.digit_nibbles  !== want.digit_nibbles  ||
                   rsp_payload.point_position !== want.point_position ||
                   rsp_payload.unit_inch      !== want.unit_inch      ||
                   rsp_payload.overrun_count  !== want.overrun_count) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: reading mismatch", $realtime);
                     $display("   expected %s", reading_text(want));
                     $display("   actual   %s", reading_text(rsp_payload));
                  end
               end
            end
         end

         // Register writes are masked to the register width.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IDLE_WAIT:    idle_wait = csr_data[MS_W-1:0];
               CSR_TIMEOUT:      timeout_limit = csr_data[MS_W-1:0];
               CSR_POINT_EXPECT: point_expect = csr_data[3:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready)
            pending_readings.push_back(next_reading(req_payload));
      end
      pending_count = pending_readings.size();
   end

endmodule

[sim/tb_caliper_spc_frame_reader.sv]
module tb_caliper_spc_frame_reader
   import spcr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int                     fail_count;
   int                     pending_count;
   int                     items_sent = 0;
   int                     cycles = 0;
   logic                   calm = 1'b0;

   // Configuration as last written, used to shape the sequences.
   int                     cfg_idle = int'(IDLE_WAIT_RESET);
   int                     cfg_timeout = int'(TIMEOUT_RESET);
   logic [3:0]             cfg_point = POINT_EXPECT_RESET;

   caliper_spc_frame_reader dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   caliper_spc_frame_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver stalls at random except during the calm stretch.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 37);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offers one beat after a random gap and waits until it is taken.
   task automatic push_beat(input logic kind, input logic level);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{mode: kind, data_bit: level};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic tick();
      push_beat(MODE_TICK, 1'($urandom_range(1)));
   endtask

   task automatic clock_fall(input logic level);
      push_beat(MODE_EDGE, level);
   endtask

   // Holds off new beats until every reading is back and the block is quiet.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] idle_ms, input logic [15:0] limit_ms,
                            input logic [15:0] point_raw);
      drain();
      write_reg(CSR_IDLE_WAIT, idle_ms);
      write_reg(CSR_TIMEOUT, limit_ms);
      write_reg(CSR_POINT_EXPECT, point_raw);
      cfg_idle = int'(idle_ms);
      cfg_timeout = int'(limit_ms);
      cfg_point = point_raw[3:0];
   endtask

   // Stray caliper edges while the request is released.
   task automatic idle_noise();
      if (cfg_idle <= 300 && $urandom_range(3) == 0)
         repeat ($urandom_range(1, 3)) clock_fall(1'($urandom_range(1)));
   endtask

   // Idle wait from a fresh count, then the tick that asserts the request.
   task automatic run_request();
      for (int i = 0; i < cfg_idle; i++) begin
         idle_noise();
         tick();
      end
      idle_noise();
      tick();
   endtask

   // Full 52-bit frame with a few ticks mixed in, optional overrun, then the done tick.
   task automatic run_frame();
      logic [FRAME_BITS-1:0] bits;
      int                    style;
      int                    ticks_left;
      int                    cap;
      style = $urandom_range(7);
      bits = FRAME_BITS'({$urandom, $urandom});
      if (style == 0) begin
         bits = '0;
      end else if (style == 1) begin
         bits = '1;
      end else begin
         if ($urandom_range(3) != 0) bits[4*POINT_NIBBLE +: 4] = cfg_point;
         if ($urandom_range(1) == 0) bits[4*SIGN_NIBBLE +: 4] = SIGN_NEG;
         if ($urandom_range(1) == 0) bits[4*UNIT_NIBBLE +: 4] = 4'd0;
      end
      // Up to timeout - 1 ticks keep the frame alive; using all of them makes the
      // done tick coincide with the timeout.
      cap = (cfg_timeout - 1 < 3) ? cfg_timeout - 1 : 3;
      if (cfg_timeout <= 4 && $urandom_range(1) == 0)
         ticks_left = cfg_timeout - 1;
      else
         ticks_left = $urandom_range(0, cap);
      for (int j = 0; j < FRAME_BITS; j++) begin
         while (ticks_left > 0 && (j == FRAME_BITS - 1 || $urandom_range(24) == 0)) begin
            tick();
            ticks_left--;
         end
         clock_fall(bits[j]);
      end
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 20)) clock_fall(1'($urandom_range(1)));
      tick();
   endtask

   // Short or missing frame that runs into the timeout.
   task automatic run_dropout();
      int edges_left;
      int ticks_left;
      case ($urandom_range(3))
         0:       edges_left = 0;
         1:       edges_left = FRAME_BITS - 1;
         default: edges_left = $urandom_range(0, FRAME_BITS - 1);
      endcase
      ticks_left = cfg_timeout;
      while (edges_left + ticks_left > 0) begin
         if (edges_left > 0 && $urandom_range(edges_left + ticks_left - 1) < edges_left) begin
            clock_fall(1'($urandom_range(1)));
            edges_left--;
         end else begin
            tick();
            ticks_left--;
         end
      end
   endtask

   task automatic read_cycle();
      run_request();
      if (cfg_timeout != 16'hFFFF && $urandom_range(9) < 3 &&
          (cfg_timeout <= 8 || $urandom_range(3) == 0))
         run_dropout();
      else
         run_frame();
   endtask

   task automatic run_cycles(input int budget);
      int start;
      start = items_sent;
      while (items_sent - start < budget) read_cycle();
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed: fast settings, a short frame that times out, and the release after it.
      configure(16'd1, 16'd2, 16'd2);
      write_reg(CSR_UNMAPPED, 16'hFFFF);
      tick();
      tick();
      clock_fall(1'b1);
      clock_fall(1'b0);
      clock_fall(1'b1);
      clock_fall(1'b1);
      tick();
      tick();
      tick();
      tick();
      tick();
      tick();
      run_cycles(200);

      configure(IDLE_WAIT_RESET, TIMEOUT_RESET, 16'(POINT_EXPECT_RESET));
      run_cycles(250);

      configure(16'd1, 16'd1, 16'd0);
      run_cycles(250);

      // No idling on either side; the timeout never fires at its maximum.
      calm = 1'b1;
      configure(16'd3, 16'hFFFF, 16'hFFFF);
      run_cycles(250);
      calm = 1'b0;

      // A longer idle wait, for a single read cycle.
      configure(16'd40, 16'd5, 16'($urandom_range(15)));
      read_cycle();

      configure(16'd2, 16'd3, {12'hA5C, 4'($urandom_range(15))});
      run_cycles(250);

      configure(16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)),
                16'($urandom_range(16'hFFFF)));
      run_cycles(250);

      drain();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[caliper_spc_frame_reader.f]
rtl/spcr_pkg.sv
rtl/spcr_capture.sv
rtl/spcr_seq.sv
rtl/spcr_decode.sv
rtl/caliper_spc_frame_reader.sv
rtl/spcr_checker.sv
sim/caliper_spc_frame_checker.sv
sim/tb_caliper_spc_frame_reader.sv
